>>> rtl/obbsat_pkg.sv
// Shared types, widths and helpers for the OBB separating-axis test unit.
// Depends on nothing; every other file in rtl/ imports it.
package obbsat_pkg;

	// Component format: signed, rotation Q2.(COORD_BITS-3), lengths with 8 fraction bits
	localparam int COORD_BITS = 20;
	localparam int ROT_FRAC   = COORD_BITS - 3;
	localparam int WORD_W     = 3 * COORD_BITS;
	localparam int PROD_W     = 2 * COORD_BITS + 1;
	localparam int ACC_W      = 2 * COORD_BITS + 4;
	localparam int BIAS_W     = 8;
	localparam int NUM_AXES   = 15;
	localparam int AXIS_W     = 4;
	localparam int DEPTH      = 5;

	// No separating axis found
	localparam logic [AXIS_W-1:0] AXIS_NONE = '0;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic        [COORD_BITS-1:0] mag_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [ACC_W-1:0]      acc_t;
	typedef logic        [BIAS_W-1:0]     bias_t;
	typedef logic        [AXIS_W-1:0]     axis_t;
	typedef logic        [NUM_AXES-1:0]   sep_vec_t;

	typedef coord_t coord_mat_t [3][3];
	typedef mag_t   mag_mat_t   [3][3];
	typedef coord_t coord_vec_t [3];
	typedef prod_t  prod_cube_t [3][3][3];
	typedef acc_t   acc_axes_t  [NUM_AXES];

	typedef struct packed {
		logic [WORD_W-1:0] rot_row_x;
		logic [WORD_W-1:0] rot_row_y;
		logic [WORD_W-1:0] rot_row_z;
		logic [WORD_W-1:0] offset_vec;
		logic [WORD_W-1:0] half_ext_a;
		logic [WORD_W-1:0] half_ext_b;
	} in_item_t;

	typedef struct packed {
		logic  apart;
		axis_t sep_axis;
	} out_item_t;

	// Next and second-next index around three axes
	function automatic int nxt1(input int i);
		nxt1 = (i == 2) ? 0 : i + 1;
	endfunction

	function automatic int nxt2(input int i);
		nxt2 = (i == 0) ? 2 : i - 1;
	endfunction

	// Signed component k of a packed word
	function automatic coord_t comp(input logic [WORD_W-1:0] w, input int k);
		comp = coord_t'(w[k*COORD_BITS +: COORD_BITS]);
	endfunction

	// Full-precision signed product of a coordinate and a biased magnitude
	function automatic prod_t mul_cm(input coord_t c, input mag_t m);
		logic signed [COORD_BITS:0] ms;
		ms = {1'b0, m};
		mul_cm = c * ms;
	endfunction

	// Full-precision signed product of two coordinates
	function automatic prod_t mul_cc(input coord_t c, input coord_t d);
		mul_cc = c * d;
	endfunction

endpackage

>>> rtl/obbsat_prod.sv
// Stages 1 and 2: unpack the box pair, form |R| + bias, then all 81 products.
// Depends on obbsat_pkg.
module obbsat_prod import obbsat_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  in_item_t   pair,
	input  bias_t      abs_bias,
	output prod_cube_t tr_s2,
	output prod_cube_t af_s2,
	output prod_cube_t bf_s2,
	output coord_vec_t t_s2,
	output coord_vec_t a_s2,
	output coord_vec_t b_s2
);

	coord_mat_t r_s1;
	mag_mat_t   f_s1;
	coord_vec_t t_s1;
	coord_vec_t a_s1;
	coord_vec_t b_s1;
	logic [WORD_W-1:0] rows [3];

	assign rows[0] = pair.rot_row_x;
	assign rows[1] = pair.rot_row_y;
	assign rows[2] = pair.rot_row_z;

	// Stage 1: unpack components and bias the absolute rotation
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					r_s1[i][j] <= comp(rows[i], j);
					f_s1[i][j] <= (comp(rows[i], j) < 0 ? mag_t'(-comp(rows[i], j))
						: mag_t'(comp(rows[i], j))) + mag_t'(abs_bias);
				end
				t_s1[i] <= comp(pair.offset_vec, i);
				a_s1[i] <= comp(pair.half_ext_a, i);
				b_s1[i] <= comp(pair.half_ext_b, i);
			end
		end
	end

	// Stage 2: T[a]*R[b][j], A[a]*F[b][j], Bh[a]*F[b][j]
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				for (int b = 0; b < 3; b++) begin
					for (int j = 0; j < 3; j++) begin
						tr_s2[a][b][j] <= mul_cc(t_s1[a], r_s1[b][j]);
						af_s2[a][b][j] <= mul_cm(a_s1[a], f_s1[b][j]);
						bf_s2[a][b][j] <= mul_cm(b_s1[a], f_s1[b][j]);
					end
				end
				t_s2[a] <= t_s1[a];
				a_s2[a] <= a_s1[a];
				b_s2[a] <= b_s1[a];
			end
		end
	end

endmodule

>>> rtl/obbsat_sum.sv
// Stage 3: projected distance and projected radius for each of the 15 axes.
// Depends on obbsat_pkg; takes the products of obbsat_prod.
module obbsat_sum import obbsat_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  prod_cube_t tr_s2,
	input  prod_cube_t af_s2,
	input  prod_cube_t bf_s2,
	input  coord_vec_t t_s2,
	input  coord_vec_t a_s2,
	input  coord_vec_t b_s2,
	output acc_axes_t  dist_s3,
	output acc_axes_t  rad_s3
);

	acc_axes_t dist_c;
	acc_axes_t rad_c;

	// Index axes in test order: A0 B0 A1 A2 B1 B2, then Ai x Bj
	always_comb begin
		int fa [3];
		int fb [3];
		int k;
		fa[0] = 0; fa[1] = 2; fa[2] = 3;
		fb[0] = 1; fb[1] = 4; fb[2] = 5;
		for (int n = 0; n < NUM_AXES; n++) begin
			dist_c[n] = '0;
			rad_c[n]  = '0;
		end
		// Face axes of box A
		for (int i = 0; i < 3; i++) begin
			dist_c[fa[i]] = acc_t'(t_s2[i]) <<< ROT_FRAC;
			rad_c[fa[i]]  = (acc_t'(a_s2[i]) <<< ROT_FRAC) + acc_t'(bf_s2[0][i][0])
				+ acc_t'(bf_s2[1][i][1]) + acc_t'(bf_s2[2][i][2]);
		end
		// Face axes of box B
		for (int j = 0; j < 3; j++) begin
			dist_c[fb[j]] = acc_t'(tr_s2[0][0][j]) + acc_t'(tr_s2[1][1][j])
				+ acc_t'(tr_s2[2][2][j]);
			rad_c[fb[j]]  = (acc_t'(b_s2[j]) <<< ROT_FRAC) + acc_t'(af_s2[0][0][j])
				+ acc_t'(af_s2[1][1][j]) + acc_t'(af_s2[2][2][j]);
		end
		// Edge cross-product axes
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				k = 6 + 3 * i + j;
				dist_c[k] = acc_t'(tr_s2[nxt2(i)][nxt1(i)][j])
					- acc_t'(tr_s2[nxt1(i)][nxt2(i)][j]);
				rad_c[k]  = acc_t'(af_s2[nxt1(i)][nxt2(i)][j])
					+ acc_t'(af_s2[nxt2(i)][nxt1(i)][j])
					+ acc_t'(bf_s2[nxt1(j)][i][nxt2(j)])
					+ acc_t'(bf_s2[nxt2(j)][i][nxt1(j)]);
			end
		end
	end

	// Register the sums
	always_ff @(posedge clk) begin
		if (en) begin
			dist_s3 <= dist_c;
			rad_s3  <= rad_c;
		end
	end

endmodule

>>> rtl/obbsat_pick.sv
// Stages 4 and 5: compare |distance| with radius per axis, then pick the first.
// Depends on obbsat_pkg; takes the sums of obbsat_sum.
module obbsat_pick import obbsat_pkg::*; (
	input  logic      clk,
	input  logic      en,
	input  acc_axes_t dist_s3,
	input  acc_axes_t rad_s3,
	output out_item_t res_s5
);

	sep_vec_t sep_s4;
	axis_t    first_c;

	// Stage 4: an axis separates when |distance| exceeds the radius
	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < NUM_AXES; n++) begin
				sep_s4[n] <= ((dist_s3[n] < 0) ? -dist_s3[n] : dist_s3[n]) > rad_s3[n];
			end
		end
	end

	// Find the lowest-numbered separating axis
	always_comb begin
		first_c = AXIS_NONE;
		for (int n = NUM_AXES - 1; n >= 0; n--) begin
			if (sep_s4[n]) begin
				first_c = axis_t'(n + 1);
			end
		end
	end

	// Stage 5: result register
	always_ff @(posedge clk) begin
		if (en) begin
			res_s5.apart    <= (first_c != AXIS_NONE);
			res_s5.sep_axis <= first_c;
		end
	end

endmodule

>>> rtl/obb_separating_axis_test_unit.sv
// Top level of the OBB separating-axis test unit: handshake, bias register, valid chain.
// Depends on obbsat_pkg, obbsat_prod, obbsat_sum and obbsat_pick.
//
// Usage:
//   pair channel (pair_valid/pair_ready/pair) takes one box pair per item: the
//   rotation of box B in box A's frame as three packed rows, the offset and both
//   half extents, all 20-bit signed components.
//   result channel (result_valid/result_ready/result) returns one item per pair:
//   apart and the number of the first separating axis (0 on overlap), in order.
//   cfg_we/cfg_wdata write the bias added to each |R| entry; write it while idle.
// Pipeline: five register stages (unpack, products, sums, compare, pick) carry
//   each accepted pair through to result_valid.
// Throughput: one pair per unstalled cycle; all 81 products run in parallel in stage 2.
// Reset: arst_n clears every valid bit and sets the bias to 1; no pairs in flight.
// Stall: while result_valid is high and result_ready low the whole pipeline
//   holds and pair_ready drops; nothing is lost or repeated.
module obb_separating_axis_test_unit import obbsat_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pair_valid,
	output logic      pair_ready,
	input  in_item_t  pair,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result,
	input  logic      cfg_we,
	input  bias_t     cfg_wdata
);

	logic            en;
	bias_t           abs_bias_q;
	logic [DEPTH-1:0] vld_q;
	prod_cube_t      tr_s2;
	prod_cube_t      af_s2;
	prod_cube_t      bf_s2;
	coord_vec_t      t_s2;
	coord_vec_t      a_s2;
	coord_vec_t      b_s2;
	acc_axes_t       dist_s3;
	acc_axes_t       rad_s3;

	// Advance the pipeline unless the result register is full and stalled
	assign en           = !vld_q[DEPTH-1] || result_ready;
	assign pair_ready   = en;
	assign result_valid = vld_q[DEPTH-1];

	// Hold the bias register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abs_bias_q <= bias_t'(1);
		end else if (cfg_we) begin
			abs_bias_q <= cfg_wdata;
		end
	end

	// Shift valid bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], pair_valid};
		end
	end

	obbsat_prod u_prod (
		.clk      (clk),
		.en       (en),
		.pair     (pair),
		.abs_bias (abs_bias_q),
		.tr_s2    (tr_s2),
		.af_s2    (af_s2),
		.bf_s2    (bf_s2),
		.t_s2     (t_s2),
		.a_s2     (a_s2),
		.b_s2     (b_s2)
	);

	obbsat_sum u_sum (
		.clk     (clk),
		.en      (en),
		.tr_s2   (tr_s2),
		.af_s2   (af_s2),
		.bf_s2   (bf_s2),
		.t_s2    (t_s2),
		.a_s2    (a_s2),
		.b_s2    (b_s2),
		.dist_s3 (dist_s3),
		.rad_s3  (rad_s3)
	);

	obbsat_pick u_pick (
		.clk     (clk),
		.en      (en),
		.dist_s3 (dist_s3),
		.rad_s3  (rad_s3),
		.res_s5  (result)
	);

endmodule

>>> rtl/obbsat_check.sv
// Port-level checks for the OBB separating-axis test unit, bound to the top level.
// Depends on obbsat_pkg and obb_separating_axis_test_unit.
module obbsat_check import obbsat_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      pair_valid,
	input logic      pair_ready,
	input logic      result_valid,
	input logic      result_ready,
	input out_item_t result
);

	// A stalled result item holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result item changed");

	// apart agrees with the axis number
	a_apart_axis: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.apart == (result.sep_axis != AXIS_NONE)))
		else $error("apart and sep_axis disagree");

	// A stalled result blocks new items
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !pair_ready)
		else $error("item accepted while the pipeline is stalled");

	// With no result waiting the unit takes items
	a_free_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> pair_ready)
		else $error("pair_ready low with an empty result register");

endmodule

bind obb_separating_axis_test_unit obbsat_check u_check (.*);
